[src/mspt_pkg.sv]
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared constants, types and helpers for the move slot pool tracker.
// ----------------------------------------------------------------------------
package mspt_pkg;

  localparam int unsigned MSPT_MAX_SLOTS    = 256;
  localparam int unsigned MSPT_SOURCE_KINDS = 6;

  localparam logic CFG_TOTAL_SLOTS    = 1'b0;
  localparam logic CFG_HIGH_THRESHOLD = 1'b1;

  localparam logic MODE_ALLOC  = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // High-occupancy period tracker state plus the period closed by this item.
  typedef struct packed {
    logic [8:0]  occ;
    logic        open;
    logic [31:0] start;
    logic        closed;
    logic [31:0] cstart;
    logic [31:0] cend;
  } trk_t;

  function automatic trk_t trk_step(trk_t s, logic [8:0] thr, logic [31:0] tick,
                                    logic up);
    trk_t r;
    r = s;
    if (thr != 9'd0) begin
      if (up) begin
        if (r.occ != 9'h1FF) r.occ = r.occ + 9'd1;
      end else if (r.occ != 9'd0) begin
        r.occ = r.occ - 9'd1;
      end
      if (r.occ >= thr) begin
        if (!r.open) begin
          r.open  = 1'b1;
          r.start = tick;
        end
      end else if (r.open) begin
        r.closed = 1'b1;
        r.cstart = r.start;
        r.cend   = tick;
        r.open   = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

[src/move_slot_pool_tracker.sv]
// ----------------------------------------------------------------------------
// move_slot_pool_tracker
// Pool of move slots kept as an ascending ring of release ticks in a RAM.
// ----------------------------------------------------------------------------
// Flow: an allocate item with a zero pool size goes straight to the result strobe; a finish
// item releases every held slot; any other allocate item releases the slots due by its
// request, then inserts its release tick unless the pool is full, shifting later entries.
// One item at a time: busy drops in the strobe cycle; each released or shifted entry is
// read through the registered RAM read port. Results cannot be stalled.
// Reset (rst_n low, synchronous) empties the pool and clears all statistics.
module move_slot_pool_tracker
  import mspt_pkg::*;
#(
  parameter int unsigned MAX_SLOTS    = MSPT_MAX_SLOTS,
  parameter int unsigned SOURCE_KINDS = MSPT_SOURCE_KINDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_request_time,
  input  logic [31:0] in_release_time,
  input  logic [2:0]  in_source_index,
  output logic        out_valid,
  output logic        out_granted,
  output logic [8:0]  out_occupancy,
  output logic [8:0]  out_peak_count,
  output logic [31:0] out_peak_tick,
  output logic [31:0] out_longest_hold,
  output logic [31:0] out_refused_total,
  output logic [31:0] out_source_total,
  output logic        out_overflow_seen,
  output logic        out_period_closed,
  output logic [31:0] out_period_start,
  output logic [31:0] out_period_end,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SW = (SOURCE_KINDS > 1) ? $clog2(SOURCE_KINDS) : 1;
  localparam logic [CW:0] MAX_W = (CW + 1)'(MAX_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE, S_REL_RD, S_REL_CHK, S_POST, S_INS_RD, S_INS_CHK, S_INS_FIN, S_DONE
  } state_t;

  state_t          state_r;
  logic [8:0]      total_r, thr_r;
  logic [AW-1:0]   head_r;
  logic [CW-1:0]   cnt_r, pos_r;
  trk_t            trk_r;
  logic [CW-1:0]   peak_r;
  logic [31:0]     peak_tick_r, longest_r, refused_r;
  logic            overflow_r, granted_r, mode_r;
  logic [31:0]     src_cnt_r [SOURCE_KINDS];
  logic [31:0]     req_r, eff_r;
  logic [SW-1:0]   idx_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  logic [CW-1:0]   limit;
  logic [SW-1:0]   idx_in;
  logic [CW-1:0]   cnt_inc;

  function automatic logic [AW-1:0] ring(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= MAX_W) s = s - MAX_W;
    return AW'(s);
  endfunction

  assign limit  = (32'(total_r) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(total_r);
  assign idx_in = (32'(in_source_index) < SOURCE_KINDS - 1)
                  ? SW'(in_source_index) : SW'(SOURCE_KINDS - 1);
  assign cnt_inc = cnt_r + CW'(1);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ring(head_r, pos_r);
    ram_wdata = eff_r;
    ram_raddr = head_r;
    case (state_r)
      S_INS_RD:  ram_raddr = ring(head_r, pos_r - CW'(1));
      S_INS_CHK: begin
        ram_we = 1'b1;
        if (ram_rdata > eff_r) ram_wdata = ram_rdata;
      end
      S_INS_FIN: ram_we = 1'b1;
      default: ;
    endcase
  end

  mspt_ram #(.WIDTH(32), .DEPTH(MAX_SLOTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= 9'd256;
      thr_r       <= 9'd0;
      head_r      <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      trk_r       <= '0;
      peak_r      <= '0;
      peak_tick_r <= '0;
      longest_r   <= '0;
      refused_r   <= '0;
      overflow_r  <= 1'b0;
      granted_r   <= 1'b0;
      out_valid   <= 1'b0;
      for (int i = 0; i < SOURCE_KINDS; i++) src_cnt_r[i] <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_we) begin
            if (cfg_index == CFG_TOTAL_SLOTS) begin
              total_r <= cfg_wdata;
            end else begin
              thr_r      <= cfg_wdata;
              trk_r.occ  <= 9'd0;
              trk_r.open <= 1'b0;
            end
          end
          if (start) begin
            mode_r       <= in_mode;
            req_r        <= in_request_time;
            eff_r        <= (in_release_time > in_request_time)
                            ? in_release_time : in_request_time;
            idx_r        <= idx_in;
            granted_r    <= 1'b0;
            trk_r.closed <= 1'b0;
            trk_r.cstart <= '0;
            trk_r.cend   <= '0;
            if (in_mode == MODE_ALLOC && total_r == 9'd0) state_r <= S_DONE;
            else state_r <= S_REL_RD;
          end
        end
        S_REL_RD: state_r <= (cnt_r == '0) ? S_POST : S_REL_CHK;
        S_REL_CHK: begin
          if (mode_r == MODE_FINISH || ram_rdata <= req_r) begin
            trk_r   <= trk_step(trk_r, thr_r, ram_rdata, 1'b0);
            head_r  <= ring(head_r, CW'(1));
            cnt_r   <= cnt_r - CW'(1);
            state_r <= S_REL_RD;
          end else begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (mode_r == MODE_FINISH) begin
            if (thr_r != 9'd0 && trk_r.open) begin
              trk_r.closed <= 1'b1;
              trk_r.cstart <= trk_r.start;
              trk_r.cend   <= trk_r.start;
              trk_r.open   <= 1'b0;
            end
            state_r <= S_DONE;
          end else if (cnt_r >= limit) begin
            overflow_r <= 1'b1;
            refused_r  <= sat_inc(refused_r);
            state_r    <= S_DONE;
          end else begin
            pos_r   <= cnt_r;
            state_r <= S_INS_RD;
          end
        end
        S_INS_RD: state_r <= (pos_r == '0) ? S_INS_FIN : S_INS_CHK;
        S_INS_CHK: begin
          // A larger entry is shifted up and written this cycle; one not larger ends the walk.
          if (ram_rdata > eff_r) begin
            pos_r   <= pos_r - CW'(1);
            state_r <= S_INS_RD;
          end else begin
            state_r <= S_INS_FIN;
          end
        end
        S_INS_FIN: begin
          cnt_r     <= cnt_inc;
          trk_r     <= trk_step(trk_r, thr_r, req_r, 1'b1);
          if (cnt_inc > peak_r) begin
            peak_r      <= cnt_inc;
            peak_tick_r <= req_r;
          end
          if (eff_r - req_r > longest_r) longest_r <= eff_r - req_r;
          src_cnt_r[idx_r] <= sat_inc(src_cnt_r[idx_r]);
          granted_r <= 1'b1;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_granted       <= granted_r;
      out_occupancy     <= 9'(cnt_r);
      out_peak_count    <= 9'(peak_r);
      out_peak_tick     <= peak_tick_r;
      out_longest_hold  <= longest_r;
      out_refused_total <= refused_r;
      out_source_total  <= src_cnt_r[idx_r];
      out_overflow_seen <= overflow_r;
      out_period_closed <= trk_r.closed;
      out_period_start  <= trk_r.cstart;
      out_period_end    <= trk_r.cend;
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not start");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CW + 1)'(cnt_r) <= MAX_W) else $error("held count beyond store");
  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(overflow_r) |-> overflow_r) else $error("overflow cleared");

endmodule

[src/mspt_ram.sv]
// ----------------------------------------------------------------------------
// mspt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mspt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
